/* hdl/cota_pkg.sv */
`timescale 1ns / 1ps

package cota_pkg;

    localparam int TEMP_W  = 8;
    localparam int DELAY_W = 8;
    localparam int COUNT_W = 8;
    localparam int MODE_W  = 2;
    localparam int LEVEL_W = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_CLEAR = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_FAULT = 2'd2
    } level_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CHARGE    = 2'd1,
        MODE_DISCHARGE = 2'd2,
        MODE_UNUSED    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_CHG_WARN_LIMIT  = 3'd0,
        REG_CHG_FAULT_LIMIT = 3'd1,
        REG_DIS_WARN_LIMIT  = 3'd2,
        REG_DIS_FAULT_LIMIT = 3'd3,
        REG_CHG_FAULT_DELAY = 3'd4,
        REG_CHG_WARN_DELAY  = 3'd5,
        REG_DIS_FAULT_DELAY = 3'd6,
        REG_DIS_WARN_DELAY  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] warn_limit;
        logic signed [TEMP_W-1:0] fault_limit;
        logic [DELAY_W-1:0]       fault_delay;
        logic [DELAY_W-1:0]       warn_delay;
    } chan_cfg_t;

    localparam chan_cfg_t CHG_CFG_RESET = '{
        warn_limit:  8'sd45,
        fault_limit: 8'sd55,
        fault_delay: 8'd125,
        warn_delay:  8'd125
    };

    localparam chan_cfg_t DIS_CFG_RESET = '{
        warn_limit:  8'sd55,
        fault_limit: 8'sd60,
        fault_delay: 8'd125,
        warn_delay:  8'd125
    };

endpackage

/* hdl/cell_over_temp_alarm.sv */
`timescale 1ns / 1ps

// cell over-temperature alarm, charge and discharge channels with a shared
// persistence counter
// input channel s_*: one beat per temperature tick (hottest cell temperature
// and battery mode); result channel m_*: one beat per input beat with both
// channel levels and a one-beat trip request
// a beat is held in the input register while the state update and the result
// are formed into the output register, from which m_valid is driven;
// throughput 1 beat per cycle while m_ready stays high
// the input register takes a new beat while a result waits, so one beat is
// held on each side when m_ready is low; s_ready falls only when both are full
// the limits and delays sit behind the apb port at byte address 4*index;
// the user writes them only while no beat is in flight; the block does not check
// reset (aresetn low, synchronous) empties both stages, clears both levels and
// the counter, and restores the default limits and delays

module cell_over_temp_alarm
    import cota_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [TEMP_W-1:0] s_hottest_temp,
    input  logic [MODE_W-1:0]        s_battery_mode,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [LEVEL_W-1:0]       m_charge_level,
    output logic [LEVEL_W-1:0]       m_discharge_level,
    output logic                     m_trip_request
);

    chan_cfg_t                chg_cfg_reg;
    chan_cfg_t                dis_cfg_reg;
    reg_index_t               cfg_index;
    logic                     cfg_write;

    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    mode_t                    in_mode_reg;

    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    level_t                   chg_level_reg;
    level_t                   chg_level_next;
    level_t                   dis_level_reg;
    level_t                   dis_level_next;
    logic                     trip_next;

    logic                     out_valid_reg;
    level_t                   out_chg_reg;
    level_t                   out_dis_reg;
    logic                     out_trip_reg;

    logic                     out_free;
    logic                     advance;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chg_cfg_reg <= CHG_CFG_RESET;
            dis_cfg_reg <= DIS_CFG_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_CHG_WARN_LIMIT:  chg_cfg_reg.warn_limit  <= pwdata[TEMP_W-1:0];
                REG_CHG_FAULT_LIMIT: chg_cfg_reg.fault_limit <= pwdata[TEMP_W-1:0];
                REG_DIS_WARN_LIMIT:  dis_cfg_reg.warn_limit  <= pwdata[TEMP_W-1:0];
                REG_DIS_FAULT_LIMIT: dis_cfg_reg.fault_limit <= pwdata[TEMP_W-1:0];
                REG_CHG_FAULT_DELAY: chg_cfg_reg.fault_delay <= pwdata[DELAY_W-1:0];
                REG_CHG_WARN_DELAY:  chg_cfg_reg.warn_delay  <= pwdata[DELAY_W-1:0];
                REG_DIS_FAULT_DELAY: dis_cfg_reg.fault_delay <= pwdata[DELAY_W-1:0];
                REG_DIS_WARN_DELAY:  dis_cfg_reg.warn_delay  <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_CHG_WARN_LIMIT:  prdata = DATA_W'(unsigned'(chg_cfg_reg.warn_limit));
            REG_CHG_FAULT_LIMIT: prdata = DATA_W'(unsigned'(chg_cfg_reg.fault_limit));
            REG_DIS_WARN_LIMIT:  prdata = DATA_W'(unsigned'(dis_cfg_reg.warn_limit));
            REG_DIS_FAULT_LIMIT: prdata = DATA_W'(unsigned'(dis_cfg_reg.fault_limit));
            REG_CHG_FAULT_DELAY: prdata = DATA_W'(chg_cfg_reg.fault_delay);
            REG_CHG_WARN_DELAY:  prdata = DATA_W'(chg_cfg_reg.warn_delay);
            REG_DIS_FAULT_DELAY: prdata = DATA_W'(dis_cfg_reg.fault_delay);
            REG_DIS_WARN_DELAY:  prdata = DATA_W'(dis_cfg_reg.warn_delay);
            default:             prdata = '0;
        endcase
    end

    // handshake between the two stages
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_temp_reg <= s_hottest_temp;
            in_mode_reg <= mode_t'(s_battery_mode);
        end
    end

    cota_step u_step (
        .temp           (in_temp_reg),
        .mode           (in_mode_reg),
        .count          (count_reg),
        .chg_level      (chg_level_reg),
        .dis_level      (dis_level_reg),
        .chg_cfg        (chg_cfg_reg),
        .dis_cfg        (dis_cfg_reg),
        .count_next     (count_next),
        .chg_level_next (chg_level_next),
        .dis_level_next (dis_level_next),
        .trip           (trip_next)
    );

    // alarm state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            chg_level_reg <= LVL_CLEAR;
            dis_level_reg <= LVL_CLEAR;
        end else if (advance) begin
            count_reg     <= count_next;
            chg_level_reg <= chg_level_next;
            dis_level_reg <= dis_level_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_chg_reg  <= chg_level_next;
            out_dis_reg  <= dis_level_next;
            out_trip_reg <= trip_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_charge_level    = out_chg_reg;
    assign m_discharge_level = out_dis_reg;
    assign m_trip_request    = out_trip_reg;

endmodule

/* hdl/cota_step.sv */
`timescale 1ns / 1ps

module cota_step
    import cota_pkg::*;
(
    input  logic signed [TEMP_W-1:0] temp,
    input  mode_t                    mode,
    input  logic [COUNT_W-1:0]       count,
    input  level_t                   chg_level,
    input  level_t                   dis_level,
    input  chan_cfg_t                chg_cfg,
    input  chan_cfg_t                dis_cfg,
    output logic [COUNT_W-1:0]       count_next,
    output level_t                   chg_level_next,
    output level_t                   dis_level_next,
    output logic                     trip
);

    logic               do_recover;
    logic               do_detect;
    logic               use_chg;
    chan_cfg_t          ccfg;
    level_t             lvl;
    level_t             lvl_new;
    logic [COUNT_W-1:0] count_inc;

    assign count_inc = count + COUNT_W'(1);

    // pick which channel runs this beat: a latched fault takes precedence over mode
    always_comb begin
        do_recover = 1'b0;
        do_detect  = 1'b0;
        use_chg    = 1'b1;
        priority if (chg_level == LVL_FAULT) begin
            do_recover = 1'b1;
        end else if (dis_level == LVL_FAULT) begin
            do_recover = 1'b1;
            use_chg    = 1'b0;
        end else if (mode == MODE_CHARGE) begin
            do_detect = 1'b1;
        end else if (mode == MODE_DISCHARGE) begin
            do_detect = 1'b1;
            use_chg   = 1'b0;
        end else begin
            // idle and unused modes leave everything as it is
            do_detect = 1'b0;
        end
    end

    assign ccfg = use_chg ? chg_cfg : dis_cfg;
    assign lvl  = use_chg ? chg_level : dis_level;

    always_comb begin
        lvl_new    = lvl;
        count_next = count;
        trip       = 1'b0;
        if (do_recover) begin
            if (temp < ccfg.warn_limit) begin
                if (count_inc > ccfg.fault_delay) begin
                    count_next = '0;
                    lvl_new    = LVL_CLEAR;
                end else begin
                    count_next = count_inc;
                end
            end else begin
                count_next = '0;
            end
        end else if (do_detect) begin
            if (temp > ccfg.fault_limit) begin
                if (count > ccfg.fault_delay) begin
                    lvl_new = LVL_FAULT;
                    trip    = 1'b1;
                end else begin
                    count_next = count_inc;
                end
            end else if (temp > ccfg.warn_limit) begin
                if (count > ccfg.warn_delay) begin
                    lvl_new    = LVL_WARN;
                    count_next = '0;
                end else begin
                    count_next = count_inc;
                end
            end else begin
                count_next = '0;
                lvl_new    = LVL_CLEAR;
            end
        end
    end

    assign chg_level_next = (use_chg && (do_recover || do_detect)) ? lvl_new : chg_level;
    assign dis_level_next = (!use_chg && (do_recover || do_detect)) ? lvl_new : dis_level;

endmodule
